FILE: rtl/maec_pkg.sv
// shared constants, codes and types of the motion alarm escalation controller
package maec_pkg;

	// contact table limits
	localparam int MAX_CONTACTS = 16;
	localparam int EFF_MAX      = (MAX_CONTACTS < 16) ? MAX_CONTACTS : 16;

	// field widths
	localparam int CMD_W    = 3;
	localparam int ACCEL_W  = 16;
	localparam int ANGLE_W  = 11;
	localparam int STATUS_W = 3;
	localparam int ACT_W    = 3;
	localparam int CONT_W   = 4;
	localparam int MOVE_W   = 3;
	localparam int MODE_W   = 3;
	localparam int THR_W    = 15;
	localparam int TIME_W   = 16;
	localparam int COUNT_W  = 5;
	localparam int FLAGS_W  = 6;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [ANGLE_W-1:0] ANGLE_MAX = 11'd1800;
	localparam logic [TIME_W-1:0]  TIME_MAX  = 16'hFFFF;

	// commands
	localparam logic [CMD_W-1:0] CMD_ACCEL  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ANGLE  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
	localparam logic [CMD_W-1:0] CMD_STATUS = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ARM    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DISARM = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RESET  = 3'd6;

	// call status codes
	localparam logic [STATUS_W-1:0] CS_DIALING  = 3'd1;
	localparam logic [STATUS_W-1:0] CS_ALERTING = 3'd2;
	localparam logic [STATUS_W-1:0] CS_ACTIVE   = 3'd3;

	// actions
	localparam logic [ACT_W-1:0] ACT_DIAL   = 3'd0;
	localparam logic [ACT_W-1:0] ACT_ALERT  = 3'd1;
	localparam logic [ACT_W-1:0] ACT_QUERY  = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HANGUP = 3'd3;
	localparam logic [ACT_W-1:0] ACT_REBASE = 3'd4;

	// alarm modes
	localparam logic [MODE_W-1:0] MODE_DISARMED = 3'd0;
	localparam logic [MODE_W-1:0] MODE_ARMED    = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CALL     = 3'd2;
	localparam logic [MODE_W-1:0] MODE_WAIT     = 3'd3;
	localparam logic [MODE_W-1:0] MODE_COOL     = 3'd4;

	// movement kinds
	localparam logic [MOVE_W-1:0] MOVE_ROTATION = 3'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ROT_LIMIT  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VERT_THR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HORIZ_THR  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_CALL_TMO   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_POLL       = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_CONTACTS   = 3'd6;

	// register reset values
	localparam logic [ANGLE_W-1:0] RST_ROT_LIMIT = 11'd50;
	localparam logic [THR_W-1:0]   RST_VERT_THR  = 15'd640;
	localparam logic [THR_W-1:0]   RST_HORIZ_THR = 15'd512;
	localparam logic [TIME_W-1:0]  RST_CALL_TMO  = 16'd30000;
	localparam logic [TIME_W-1:0]  RST_COOLDOWN  = 16'd20000;
	localparam logic [TIME_W-1:0]  RST_POLL      = 16'd1000;
	localparam logic [COUNT_W-1:0] RST_CONTACTS  = 5'd4;

	// result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef struct packed {
		logic [ACT_W-1:0]   action;
		logic [CONT_W-1:0]  contact;
		logic [MOVE_W-1:0]  movement;
		logic [ANGLE_W-1:0] angle_report;
		logic [MODE_W-1:0]  alarm_mode;
		logic               last;
	} result_t;

endpackage

FILE: rtl/motion_alarm_escalation_controller_core.sv
// motion alarm escalation controller: event decode, escalation machine, result queue
// results of a request are written into the registered result queue when the request is taken
// throughput: one request per cycle unless in_stall; a request with two results holds the
// output for both, so the single output port sets the rate on long runs of dial/alert or reset
// input stalls while the four-entry result queue has fewer than two free slots
// arst_n clears mode to armed, all counters, flags and the queue; registers take reset values
module motion_alarm_escalation_controller_core (
	input  logic                                clk,
	input  logic                                arst_n,

	// configuration write channel
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [maec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [maec_pkg::CFG_DATA_W-1:0]     cfg_data,

	// event request channel
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic [maec_pkg::CMD_W-1:0]          command,
	input  logic signed [maec_pkg::ACCEL_W-1:0] accel_x,
	input  logic signed [maec_pkg::ACCEL_W-1:0] accel_y,
	input  logic signed [maec_pkg::ACCEL_W-1:0] accel_z,
	input  logic [maec_pkg::ANGLE_W-1:0]        angle_tenths,
	input  logic [maec_pkg::STATUS_W-1:0]       call_status,

	// result channel
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic [maec_pkg::ACT_W-1:0]          action,
	output logic [maec_pkg::CONT_W-1:0]         contact,
	output logic [maec_pkg::MOVE_W-1:0]         movement,
	output logic [maec_pkg::ANGLE_W-1:0]        angle_report,
	output logic [maec_pkg::MODE_W-1:0]         alarm_mode,
	output logic                                last
);

	// configuration registers
	logic [maec_pkg::ANGLE_W-1:0] rot_limit_q;
	logic [maec_pkg::THR_W-1:0]   vert_thr_q;
	logic [maec_pkg::THR_W-1:0]   horiz_thr_q;
	logic [maec_pkg::TIME_W-1:0]  call_tmo_q;
	logic [maec_pkg::TIME_W-1:0]  cooldown_q;
	logic [maec_pkg::TIME_W-1:0]  poll_q;
	logic [maec_pkg::COUNT_W-1:0] contacts_q;

	// machine state
	logic [maec_pkg::MODE_W-1:0]  mode_q;
	logic [maec_pkg::CONT_W-1:0]  contact_q;
	logic [maec_pkg::FLAGS_W-1:0] flags_q;
	logic [maec_pkg::ANGLE_W-1:0] angle_q;
	logic [maec_pkg::MOVE_W-1:0]  move_q;
	logic [maec_pkg::TIME_W-1:0]  call_el_q;
	logic [maec_pkg::TIME_W-1:0]  cool_el_q;
	logic [maec_pkg::TIME_W-1:0]  poll_el_q;

	// next state
	logic [maec_pkg::MODE_W-1:0]  mode_d;
	logic [maec_pkg::CONT_W-1:0]  contact_d;
	logic [maec_pkg::FLAGS_W-1:0] flags_d;
	logic [maec_pkg::ANGLE_W-1:0] angle_d;
	logic [maec_pkg::MOVE_W-1:0]  move_d;
	logic [maec_pkg::TIME_W-1:0]  call_el_d;
	logic [maec_pkg::TIME_W-1:0]  cool_el_d;
	logic [maec_pkg::TIME_W-1:0]  poll_el_d;

	// results of this request
	logic [1:0]                   n_res;
	logic [maec_pkg::ACT_W-1:0]   act0;
	logic [maec_pkg::ACT_W-1:0]   act1;
	maec_pkg::result_t            res0;
	maec_pkg::result_t            res1;

	// helpers
	logic                         in_take;
	logic [maec_pkg::COUNT_W-1:0] eff_count;
	logic [maec_pkg::COUNT_W-1:0] next_idx;
	logic [maec_pkg::CONT_W-1:0]  next_contact;
	logic [maec_pkg::TIME_W-1:0]  call_inc;
	logic [maec_pkg::TIME_W-1:0]  cool_inc;
	logic [maec_pkg::TIME_W-1:0]  poll_inc;
	logic                         rot_hit;
	logic [maec_pkg::MOVE_W-1:0]  first_dir;
	logic signed [maec_pkg::THR_W+1:0] v_pos, v_neg, h_pos, h_neg;
	logic signed [maec_pkg::THR_W+1:0] x_ext, y_ext, z_ext;

	// result queue
	maec_pkg::result_t            queue_q [maec_pkg::QDEPTH];
	logic [maec_pkg::QPTR_W-1:0]  wr_ptr_q;
	logic [maec_pkg::QPTR_W-1:0]  rd_ptr_q;
	logic [maec_pkg::QCNT_W-1:0]  count_q;
	logic                         out_take;

	assign cfg_ready = 1'b1;
	assign in_stall  = (count_q > maec_pkg::QCNT_W'(maec_pkg::QDEPTH - 2));
	assign in_take   = in_valid && !in_stall;
	assign out_valid = (count_q != '0);
	assign out_take  = out_valid && !out_stall;

	// configuration writes, indexes past the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rot_limit_q <= maec_pkg::RST_ROT_LIMIT;
			vert_thr_q  <= maec_pkg::RST_VERT_THR;
			horiz_thr_q <= maec_pkg::RST_HORIZ_THR;
			call_tmo_q  <= maec_pkg::RST_CALL_TMO;
			cooldown_q  <= maec_pkg::RST_COOLDOWN;
			poll_q      <= maec_pkg::RST_POLL;
			contacts_q  <= maec_pkg::RST_CONTACTS;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				maec_pkg::REG_ROT_LIMIT: rot_limit_q <= cfg_data[maec_pkg::ANGLE_W-1:0];
				maec_pkg::REG_VERT_THR:  vert_thr_q  <= cfg_data[maec_pkg::THR_W-1:0];
				maec_pkg::REG_HORIZ_THR: horiz_thr_q <= cfg_data[maec_pkg::THR_W-1:0];
				maec_pkg::REG_CALL_TMO:  call_tmo_q  <= cfg_data;
				maec_pkg::REG_COOLDOWN:  cooldown_q  <= cfg_data;
				maec_pkg::REG_POLL:      poll_q      <= cfg_data;
				maec_pkg::REG_CONTACTS:  contacts_q  <= cfg_data[maec_pkg::COUNT_W-1:0];
				default: ;
			endcase
		end
	end

	// contact count held in range, and round robin successor
	always_comb begin
		eff_count = contacts_q;
		if (eff_count == '0) begin
			eff_count = maec_pkg::COUNT_W'(1);
		end
		if (eff_count > maec_pkg::COUNT_W'(maec_pkg::EFF_MAX)) begin
			eff_count = maec_pkg::COUNT_W'(maec_pkg::EFF_MAX);
		end
		next_idx = {1'b0, contact_q} + maec_pkg::COUNT_W'(1);
		if (next_idx >= eff_count) begin
			next_contact = '0;
		end else begin
			next_contact = next_idx[maec_pkg::CONT_W-1:0];
		end
	end

	// saturating elapsed counters as seen by a tick
	assign call_inc = (call_el_q == maec_pkg::TIME_MAX) ? call_el_q : call_el_q + 1'b1;
	assign cool_inc = (cool_el_q == maec_pkg::TIME_MAX) ? cool_el_q : cool_el_q + 1'b1;
	assign poll_inc = (poll_el_q == maec_pkg::TIME_MAX) ? poll_el_q : poll_el_q + 1'b1;

	assign rot_hit = (angle_q >= rot_limit_q);

	// first set direction flag gives the movement kind (lift is kind 1)
	always_comb begin
		first_dir = maec_pkg::MOVE_W'(maec_pkg::FLAGS_W);
		for (int k = maec_pkg::FLAGS_W - 1; k >= 0; k--) begin
			if (flags_q[k]) begin
				first_dir = maec_pkg::MOVE_W'(k + 1);
			end
		end
	end

	// symmetric thresholds, one bit of headroom for the negation
	assign v_pos = $signed({2'b00, vert_thr_q});
	assign v_neg = -v_pos;
	assign h_pos = $signed({2'b00, horiz_thr_q});
	assign h_neg = -h_pos;
	assign x_ext = (maec_pkg::THR_W + 2)'(accel_x);
	assign y_ext = (maec_pkg::THR_W + 2)'(accel_y);
	assign z_ext = (maec_pkg::THR_W + 2)'(accel_z);

	// event decode and escalation machine
	always_comb begin
		mode_d    = mode_q;
		contact_d = contact_q;
		flags_d   = flags_q;
		angle_d   = angle_q;
		move_d    = move_q;
		call_el_d = call_el_q;
		cool_el_d = cool_el_q;
		poll_el_d = poll_el_q;
		n_res     = 2'd0;
		act0      = maec_pkg::ACT_DIAL;
		act1      = maec_pkg::ACT_DIAL;

		case (command)
			maec_pkg::CMD_ACCEL: begin
				flags_d[0] = (z_ext > v_pos);
				flags_d[1] = (z_ext < v_neg);
				flags_d[2] = (x_ext > h_pos);
				flags_d[3] = (x_ext < h_neg);
				flags_d[4] = (y_ext > h_pos);
				flags_d[5] = (y_ext < h_neg);
			end
			maec_pkg::CMD_ANGLE: begin
				angle_d = (angle_tenths > maec_pkg::ANGLE_MAX) ? maec_pkg::ANGLE_MAX : angle_tenths;
			end
			maec_pkg::CMD_TICK: begin
				call_el_d = call_inc;
				cool_el_d = cool_inc;
				poll_el_d = poll_inc;
				case (mode_q)
					maec_pkg::MODE_ARMED: begin
						if (rot_hit || (flags_q != '0)) begin
							move_d    = rot_hit ? maec_pkg::MOVE_ROTATION : first_dir;
							contact_d = '0;
							mode_d    = maec_pkg::MODE_CALL;
						end
					end
					maec_pkg::MODE_CALL: begin
						flags_d = '0;
						// a stale index past the count restarts the list
						if ({1'b0, contact_q} >= eff_count) begin
							contact_d = '0;
						end
						call_el_d = '0;
						n_res     = 2'd2;
						act0      = maec_pkg::ACT_DIAL;
						act1      = maec_pkg::ACT_ALERT;
						mode_d    = maec_pkg::MODE_WAIT;
					end
					maec_pkg::MODE_WAIT: begin
						if (call_inc >= call_tmo_q) begin
							n_res     = 2'd1;
							act0      = maec_pkg::ACT_HANGUP;
							contact_d = next_contact;
							mode_d    = maec_pkg::MODE_CALL;
						end else if (poll_inc >= poll_q) begin
							n_res     = 2'd1;
							act0      = maec_pkg::ACT_QUERY;
							poll_el_d = '0;
						end
					end
					maec_pkg::MODE_COOL: begin
						if (cool_inc >= cooldown_q) begin
							if (rot_hit) begin
								contact_d = '0;
								mode_d    = maec_pkg::MODE_CALL;
							end else begin
								mode_d    = maec_pkg::MODE_ARMED;
							end
						end
					end
					default: ;
				endcase
			end
			maec_pkg::CMD_STATUS: begin
				if (mode_q == maec_pkg::MODE_WAIT) begin
					if (call_status == maec_pkg::CS_ACTIVE) begin
						cool_el_d = '0;
						mode_d    = maec_pkg::MODE_COOL;
					end else if (!(call_status inside {maec_pkg::CS_DIALING,
						maec_pkg::CS_ALERTING})) begin
						// none, disconnected and unknown codes drop to the next contact
						contact_d = next_contact;
						mode_d    = maec_pkg::MODE_CALL;
					end
				end
			end
			maec_pkg::CMD_ARM: begin
				mode_d = maec_pkg::MODE_ARMED;
				n_res  = 2'd1;
				act0   = maec_pkg::ACT_REBASE;
			end
			maec_pkg::CMD_DISARM: begin
				mode_d = maec_pkg::MODE_DISARMED;
				n_res  = 2'd1;
				act0   = maec_pkg::ACT_HANGUP;
			end
			maec_pkg::CMD_RESET: begin
				mode_d = maec_pkg::MODE_ARMED;
				n_res  = 2'd2;
				act0   = maec_pkg::ACT_HANGUP;
				act1   = maec_pkg::ACT_REBASE;
			end
			default: ;
		endcase
	end

	// results carry the state left by this request
	always_comb begin
		res0.action       = act0;
		res0.contact      = contact_d;
		res0.movement     = move_d;
		res0.angle_report = angle_d;
		res0.alarm_mode   = mode_d;
		res0.last         = (n_res == 2'd1);
		res1              = res0;
		res1.action       = act1;
		res1.last         = 1'b1;
	end

	// state update on each accepted request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= maec_pkg::MODE_ARMED;
			contact_q <= '0;
			flags_q   <= '0;
			angle_q   <= '0;
			move_q    <= '0;
			call_el_q <= '0;
			cool_el_q <= '0;
			poll_el_q <= '0;
		end else if (in_take) begin
			mode_q    <= mode_d;
			contact_q <= contact_d;
			flags_q   <= flags_d;
			angle_q   <= angle_d;
			move_q    <= move_d;
			call_el_q <= call_el_d;
			cool_el_q <= cool_el_d;
			poll_el_q <= poll_el_d;
		end
	end

	// result queue entries, no reset needed on the payload
	always_ff @(posedge clk) begin
		if (in_take && (n_res != 2'd0)) begin
			queue_q[wr_ptr_q] <= res0;
			if (n_res == 2'd2) begin
				queue_q[wr_ptr_q + 1'b1] <= res1;
			end
		end
	end

	// queue pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (in_take) begin
				wr_ptr_q <= wr_ptr_q + maec_pkg::QPTR_W'(n_res);
			end
			if (out_take) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + (in_take ? maec_pkg::QCNT_W'(n_res) : '0)
				- (out_take ? maec_pkg::QCNT_W'(1) : '0);
		end
	end

	// head of the queue drives the result ports
	assign action       = queue_q[rd_ptr_q].action;
	assign contact      = queue_q[rd_ptr_q].contact;
	assign movement     = queue_q[rd_ptr_q].movement;
	assign angle_report = queue_q[rd_ptr_q].angle_report;
	assign alarm_mode   = queue_q[rd_ptr_q].alarm_mode;
	assign last         = queue_q[rd_ptr_q].last;

endmodule

FILE: test/motion_alarm_escalation_controller_core_tb.sv
`timescale 1ns / 1ps
// self-checking testbench of the motion alarm escalation controller core
module motion_alarm_escalation_controller_core_tb;
	import maec_pkg::*;

	// run control
	localparam int WATCHDOG_LIMIT = 5000;  // cycles with no request moving on any channel
	localparam int SETTLE_CYCLES  = 8;     // quiet cycles before a register write
	localparam int TAIL_CYCLES    = 20;    // quiet cycles before the verdict
	localparam int MAX_SHOWN      = 10;    // mismatches printed in full
	localparam int HOLD_CYCLES    = 400;   // long receiver hold-off

	// codes the package leaves unnamed
	localparam logic [CMD_W-1:0]     CMD_UNUSED      = 3'd7;
	localparam logic [STATUS_W-1:0]  CS_NONE         = 3'd0;
	localparam logic [STATUS_W-1:0]  CS_DISCONNECTED = 3'd4;
	localparam logic [STATUS_W-1:0]  CS_UNUSED       = 3'd7;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED      = 3'd7;

	typedef enum {SET_RANDOM, SET_LOWEST, SET_HIGHEST} setting_t;

	// dut ports, all inputs known from time zero
	logic                        clk          = 1'b0;
	logic                        arst_n       = 1'b0;
	logic                        cfg_valid    = 1'b0;
	logic                        cfg_ready;
	logic [CFG_IDX_W-1:0]        cfg_index    = '0;
	logic [CFG_DATA_W-1:0]       cfg_data     = '0;
	logic                        in_valid     = 1'b0;
	logic                        in_stall;
	logic [CMD_W-1:0]            command      = '0;
	logic signed [ACCEL_W-1:0]   accel_x      = '0;
	logic signed [ACCEL_W-1:0]   accel_y      = '0;
	logic signed [ACCEL_W-1:0]   accel_z      = '0;
	logic [ANGLE_W-1:0]          angle_tenths = '0;
	logic [STATUS_W-1:0]         call_status  = '0;
	logic                        out_valid;
	logic                        out_stall    = 1'b0;
	logic [ACT_W-1:0]            action;
	logic [CONT_W-1:0]           contact;
	logic [MOVE_W-1:0]           movement;
	logic [ANGLE_W-1:0]          angle_report;
	logic [MODE_W-1:0]           alarm_mode;
	logic                        last;

	// traffic shaping, set by the test tasks
	int idle_pct   = 0;  // chance in a hundred that the sender idles a cycle
	int stall_pct  = 0;  // chance in a hundred that the receiver stalls a cycle
	int hold_left  = 0;  // cycles of forced receiver hold-off still to go

	// bookkeeping
	int faults          = 0;
	int events_sent     = 0;
	int actions_checked = 0;
	int reg_writes      = 0;
	int quiet_cycles    = 0;

	// tracked copy of the registers
	logic [ANGLE_W-1:0] lim_rotation;
	logic [THR_W-1:0]   lim_vertical;
	logic [THR_W-1:0]   lim_horizontal;
	logic [TIME_W-1:0]  tmo_call;
	logic [TIME_W-1:0]  tmo_cooldown;
	logic [TIME_W-1:0]  tmo_poll;
	logic [COUNT_W-1:0] n_contacts;

	// tracked copy of the escalation state
	logic [MODE_W-1:0]  cur_mode;
	logic [CONT_W-1:0]  cur_contact;
	logic [FLAGS_W-1:0] cur_flags;     // bit0 lift .. bit5 backward
	logic [ANGLE_W-1:0] cur_angle;
	logic [MOVE_W-1:0]  cur_movement;
	logic [TIME_W-1:0]  call_ms;
	logic [TIME_W-1:0]  cool_ms;
	logic [TIME_W-1:0]  poll_ms;

	// actions the block owes us, oldest first
	result_t expected_actions[$];

	motion_alarm_escalation_controller_core u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.command      (command),
		.accel_x      (accel_x),
		.accel_y      (accel_y),
		.accel_z      (accel_z),
		.angle_tenths (angle_tenths),
		.call_status  (call_status),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.action       (action),
		.contact      (contact),
		.movement     (movement),
		.angle_report (angle_report),
		.alarm_mode   (alarm_mode),
		.last         (last)
	);

	// 2 ns clock
	always #1 clk = ~clk;

	// ---------------------------------------------------------------- tracker

	function automatic void reset_tracker();
		lim_rotation   = RST_ROT_LIMIT;
		lim_vertical   = RST_VERT_THR;
		lim_horizontal = RST_HORIZ_THR;
		tmo_call       = RST_CALL_TMO;
		tmo_cooldown   = RST_COOLDOWN;
		tmo_poll       = RST_POLL;
		n_contacts     = RST_CONTACTS;
		cur_mode       = MODE_ARMED;
		cur_contact    = '0;
		cur_flags      = '0;
		cur_angle      = '0;
		cur_movement   = MOVE_ROTATION;
		call_ms        = '0;
		cool_ms        = '0;
		poll_ms        = '0;
	endfunction

	// register write as the block stores it, narrow registers drop the upper data bits
	function automatic void track_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		case (idx)
		REG_ROT_LIMIT: lim_rotation   = data[ANGLE_W-1:0];
		REG_VERT_THR:  lim_vertical   = data[THR_W-1:0];
		REG_HORIZ_THR: lim_horizontal = data[THR_W-1:0];
		REG_CALL_TMO:  tmo_call       = data[TIME_W-1:0];
		REG_COOLDOWN:  tmo_cooldown   = data[TIME_W-1:0];
		REG_POLL:      tmo_poll       = data[TIME_W-1:0];
		REG_CONTACTS:  n_contacts     = data[COUNT_W-1:0];
		default: ;
		endcase
	endfunction

	// contact count held within 1..EFF_MAX
	function automatic int unsigned active_contacts();
		int unsigned c;
		c = n_contacts;
		if (c < 1) c = 1;
		if (c > EFF_MAX) c = EFF_MAX;
		return c;
	endfunction

	function automatic void advance_contact();
		int unsigned nxt;
		nxt = cur_contact + 1;
		if (nxt >= active_contacts()) nxt = 0;
		cur_contact = CONT_W'(nxt);
	endfunction

	function automatic logic [TIME_W-1:0] bump(input logic [TIME_W-1:0] v);
		return (v == TIME_MAX) ? v : v + 1'b1;
	endfunction

	// work out what one accepted event does and queue the actions it owes
	function automatic void track_event(input logic [CMD_W-1:0] cmd,
			input logic signed [ACCEL_W-1:0] ax, input logic signed [ACCEL_W-1:0] ay,
			input logic signed [ACCEL_W-1:0] az, input logic [ANGLE_W-1:0] ang,
			input logic [STATUS_W-1:0] st);
		logic [ACT_W-1:0]   acts[2];
		logic [FLAGS_W-1:0] f;
		int                 n;
		int                 vt;
		int                 ht;
		int                 k;
		result_t            r;
		n  = 0;
		vt = lim_vertical;
		ht = lim_horizontal;
		case (cmd)
		CMD_ACCEL: begin
			// symmetric thresholds, strict compare
			f = '0;
			if (int'(az) > vt)  f[0] = 1'b1;
			if (int'(az) < -vt) f[1] = 1'b1;
			if (int'(ax) > ht)  f[2] = 1'b1;
			if (int'(ax) < -ht) f[3] = 1'b1;
			if (int'(ay) > ht)  f[4] = 1'b1;
			if (int'(ay) < -ht) f[5] = 1'b1;
			cur_flags = f;
		end
		CMD_ANGLE: begin
			cur_angle = (ang > ANGLE_MAX) ? ANGLE_MAX : ang;
		end
		CMD_TICK: begin
			call_ms = bump(call_ms);
			cool_ms = bump(cool_ms);
			poll_ms = bump(poll_ms);
			case (cur_mode)
			MODE_ARMED: begin
				if (cur_angle >= lim_rotation || cur_flags != '0) begin
					// rotation wins, then the lowest direction flag
					if (cur_angle >= lim_rotation) begin
						cur_movement = MOVE_ROTATION;
					end else begin
						k = 0;
						while (k < FLAGS_W && !cur_flags[k]) k++;
						cur_movement = MOVE_W'(k + 1);
					end
					cur_contact = '0;
					cur_mode    = MODE_CALL;
				end
			end
			MODE_CALL: begin
				cur_flags = '0;
				if (cur_contact >= active_contacts()) cur_contact = '0;
				call_ms  = '0;
				acts[0]  = ACT_DIAL;
				acts[1]  = ACT_ALERT;
				n        = 2;
				cur_mode = MODE_WAIT;
			end
			MODE_WAIT: begin
				if (call_ms >= tmo_call) begin
					acts[0] = ACT_HANGUP;
					n       = 1;
					advance_contact();
					cur_mode = MODE_CALL;
				end else if (poll_ms >= tmo_poll) begin
					acts[0] = ACT_QUERY;
					n       = 1;
					poll_ms = '0;
				end
			end
			MODE_COOL: begin
				if (cool_ms >= tmo_cooldown) begin
					if (cur_angle >= lim_rotation) begin
						cur_contact = '0;
						cur_mode    = MODE_CALL;
					end else begin
						cur_mode = MODE_ARMED;
					end
				end
			end
			default: ;
			endcase
		end
		CMD_STATUS: begin
			// only a waiting call listens to the status
			if (cur_mode == MODE_WAIT) begin
				case (st)
				CS_ACTIVE: begin
					cool_ms  = '0;
					cur_mode = MODE_COOL;
				end
				CS_DIALING, CS_ALERTING: ;
				default: begin
					advance_contact();
					cur_mode = MODE_CALL;
				end
				endcase
			end
		end
		CMD_ARM: begin
			cur_mode = MODE_ARMED;
			acts[0]  = ACT_REBASE;
			n        = 1;
		end
		CMD_DISARM: begin
			cur_mode = MODE_DISARMED;
			acts[0]  = ACT_HANGUP;
			n        = 1;
		end
		CMD_RESET: begin
			acts[0]  = ACT_HANGUP;
			acts[1]  = ACT_REBASE;
			n        = 2;
			cur_mode = MODE_ARMED;
		end
		default: ;
		endcase
		// every action carries the state as it stands after the event
		for (int i = 0; i < n; i++) begin
			r.action       = acts[i];
			r.contact      = cur_contact;
			r.movement     = cur_movement;
			r.angle_report = cur_angle;
			r.alarm_mode   = cur_mode;
			r.last         = (i == n - 1);
			expected_actions.push_back(r);
		end
	endfunction

	// ---------------------------------------------------------------- drivers

	// one event request; valid stays up between back-to-back requests
	task automatic send_event(input logic [CMD_W-1:0] cmd,
			input logic signed [ACCEL_W-1:0] ax, input logic signed [ACCEL_W-1:0] ay,
			input logic signed [ACCEL_W-1:0] az, input logic [ANGLE_W-1:0] ang,
			input logic [STATUS_W-1:0] st);
		if ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		in_valid     <= 1'b1;
		command      <= cmd;
		accel_x      <= ax;
		accel_y      <= ay;
		accel_z      <= az;
		angle_tenths <= ang;
		call_status  <= st;
		do @(posedge clk); while (in_stall);
		track_event(cmd, ax, ay, az, ang, st);
		events_sent++;
	endtask

	// register write; more keeps valid up for a following write
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data, input bit more);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		track_reg(idx, data);
		reg_writes++;
		if (!more) cfg_valid <= 1'b0;
	endtask

	// stop sending, let every owed action come out, then give the block a few quiet cycles
	task automatic drain_results();
		in_valid <= 1'b0;
		while (expected_actions.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// value in the low bits, junk above the register width
	function automatic logic [CFG_DATA_W-1:0] noisy(input int unsigned value, input int width);
		logic [CFG_DATA_W-1:0] junk;
		logic [CFG_DATA_W-1:0] mask;
		junk = CFG_DATA_W'($urandom);
		mask = {CFG_DATA_W{1'b1}} << width;
		return (junk & mask) | (CFG_DATA_W'(value) & ~mask);
	endfunction

	task automatic load_settings(input setting_t kind);
		case (kind)
		SET_LOWEST: begin
			// all limits zero: any motion trips, every timer expires on the first tick
			write_reg(REG_UNUSED, 16'hFFFF, 1'b1);
			write_reg(REG_ROT_LIMIT, 16'd0, 1'b1);
			write_reg(REG_VERT_THR, 16'd0, 1'b1);
			write_reg(REG_HORIZ_THR, 16'd0, 1'b1);
			write_reg(REG_CALL_TMO, 16'd0, 1'b1);
			write_reg(REG_COOLDOWN, 16'd0, 1'b1);
			write_reg(REG_POLL, 16'd0, 1'b1);
			write_reg(REG_CONTACTS, 16'd0, 1'b0);
		end
		SET_HIGHEST: begin
			// all bits set: widest limits, count beyond the table
			write_reg(REG_ROT_LIMIT, 16'hFFFF, 1'b1);
			write_reg(REG_VERT_THR, 16'hFFFF, 1'b1);
			write_reg(REG_HORIZ_THR, 16'hFFFF, 1'b1);
			write_reg(REG_CALL_TMO, 16'hFFFF, 1'b1);
			write_reg(REG_COOLDOWN, 16'hFFFF, 1'b1);
			write_reg(REG_POLL, 16'hFFFF, 1'b1);
			write_reg(REG_CONTACTS, 16'hFFFF, 1'b0);
		end
		default: begin
			// short timers so calls, polls, timeouts and cooldowns all come around
			write_reg(REG_ROT_LIMIT, noisy($urandom_range(1800), ANGLE_W), 1'b1);
			write_reg(REG_VERT_THR, noisy(($urandom_range(3) == 0) ? $urandom_range(32767)
				: $urandom_range(2000), THR_W), 1'b1);
			write_reg(REG_HORIZ_THR, noisy(($urandom_range(3) == 0) ? $urandom_range(32767)
				: $urandom_range(2000), THR_W), 1'b1);
			write_reg(REG_CALL_TMO, 16'($urandom_range(40)), 1'b1);
			write_reg(REG_COOLDOWN, 16'($urandom_range(30)), 1'b1);
			write_reg(REG_POLL, 16'($urandom_range(12)), 1'b1);
			write_reg(REG_CONTACTS, noisy($urandom_range(31), COUNT_W), 1'b0);
		end
		endcase
	endtask

	// one axis: mostly inside the threshold, often right at its edge, sometimes anything
	function automatic logic signed [ACCEL_W-1:0] pick_axis(input int thr);
		int m;
		int v;
		case ($urandom_range(3))
		0, 1: m = $urandom_range(thr);
		2: m = thr + int'($urandom_range(2)) - 1;
		default: return ACCEL_W'($urandom);
		endcase
		v = $urandom_range(1) ? m : -m;
		if (v > 32767) v = 32767;
		if (v < -32768) v = -32768;
		return ACCEL_W'(v);
	endfunction

	// angle: near the rotation limit, in range, above the clamp, level, or anything
	function automatic logic [ANGLE_W-1:0] pick_angle();
		int pick;
		int a;
		pick = $urandom_range(99);
		if (pick < 30) begin
			a = int'(lim_rotation) + int'($urandom_range(2)) - 1;
			if (a < 0) a = 0;
			if (a > 2047) a = 2047;
		end else if (pick < 60) begin
			a = $urandom_range(1800);
		end else if (pick < 70) begin
			a = $urandom_range(2047, 1801);
		end else if (pick < 85) begin
			a = 0;
		end else begin
			a = $urandom_range(2047);
		end
		return ANGLE_W'(a);
	endfunction

	// random event, tick heavy so the escalation machine keeps moving
	task automatic send_random_event();
		int                  pick;
		logic [CMD_W-1:0]    cmd;
		logic [STATUS_W-1:0] st;
		pick = $urandom_range(99);
		if (pick < 50)      cmd = CMD_TICK;
		else if (pick < 62) cmd = CMD_ACCEL;
		else if (pick < 72) cmd = CMD_ANGLE;
		else if (pick < 84) cmd = CMD_STATUS;
		else if (pick < 89) cmd = CMD_ARM;
		else if (pick < 92) cmd = CMD_DISARM;
		else if (pick < 97) cmd = CMD_RESET;
		else                cmd = CMD_UNUSED;
		pick = $urandom_range(99);
		if (pick < 40)      st = CS_ACTIVE;
		else if (pick < 50) st = CS_DIALING;
		else if (pick < 60) st = CS_ALERTING;
		else                st = STATUS_W'($urandom_range(7));
		send_event(cmd, pick_axis(lim_horizontal), pick_axis(lim_horizontal),
			pick_axis(lim_vertical), pick_angle(), st);
	endtask

	// ---------------------------------------------------------------- tests

	// every command and six of the eight status codes on the reset settings, walking one full escalation
	task automatic test_directed();
		idle_pct  = 0;
		stall_pct = 0;
		send_event(CMD_ACCEL, 16'sh7FFF, 16'sh8000, 16'sh0000, '0, CS_NONE);
		send_event(CMD_ANGLE, '0, '0, '0, 11'h7FF, CS_NONE);        // clamps at the top
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);              // rotation trips
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);              // dial and alert
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_DIALING);
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_ALERTING);
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);              // poll not due yet
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_NONE);            // next contact
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_UNUSED);          // read as disconnected
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_DISCONNECTED);
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_NONE);            // wraps back to contact 0
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_ACTIVE);          // into cooldown
		send_event(CMD_STATUS, '0, '0, '0, '0, CS_NONE);            // ignored outside waiting
		send_event(CMD_ARM, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_ANGLE, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_ACCEL, 16'sh8000, 16'sh7FFF, 16'sh7FFF, '0, CS_NONE);
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);              // lift beats right and forward
		send_event(CMD_DISARM, '0, '0, '0, '0, CS_NONE);
		send_event(CMD_TICK, '0, '0, '0, '0, CS_NONE);              // disarmed stays put
		send_event(CMD_UNUSED, 16'shFFFF, 16'shFFFF, 16'shFFFF, 11'h7FF, CS_UNUSED);
		send_event(CMD_RESET, '0, '0, '0, '0, CS_NONE);
		drain_results();
	endtask

	// four traffic mixes, three register settings each, extremes among them
	task automatic test_random_traffic();
		int       idle_mix[4]  = '{0, 83, 0, 19};
		int       stall_mix[4] = '{0, 0, 83, 19};
		setting_t kind;
		for (int p = 0; p < 4; p++) begin
			idle_pct  = idle_mix[p];
			stall_pct = stall_mix[p];
			for (int k = 0; k < 3; k++) begin
				if (p == 0 && k == 0)      kind = SET_LOWEST;
				else if (p == 1 && k == 0) kind = SET_HIGHEST;
				else                       kind = SET_RANDOM;
				load_settings(kind);
				repeat (162) send_random_event();
				drain_results();
			end
		end
	endtask

	// receiver holds off while requests keep coming, so the result queue fills and stalls input
	task automatic test_backpressure();
		idle_pct  = 0;
		stall_pct = 0;
		load_settings(SET_RANDOM);
		hold_left = HOLD_CYCLES;
		repeat (12) send_event(CMD_RESET, '0, '0, '0, '0, CS_NONE);
		repeat (30) send_random_event();
		drain_results();
	endtask

	// ---------------------------------------------------------------- receiver and checks

	// random stalls, or a forced hold-off counted down here
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(99) < stall_pct);
		end
	end

	// each accepted result against the oldest owed action
	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			actions_checked++;
			if (expected_actions.size() == 0) begin
				faults++;
				if (faults <= MAX_SHOWN)
					$display("unexpected result: act %0d cont %0d move %0d",
						action, contact, movement,
						" ang %0d mode %0d last %0d", angle_report, alarm_mode, last);
			end else begin
				want = expected_actions.pop_front();
				if (want.action !== action || want.contact !== contact ||
						want.movement !== movement || want.angle_report !== angle_report ||
						want.alarm_mode !== alarm_mode || want.last !== last) begin
					faults++;
					if (faults <= MAX_SHOWN)
						$display("mismatch: want act %0d cont %0d move %0d",
							want.action, want.contact, want.movement,
							" ang %0d mode %0d last %0d,", want.angle_report,
							want.alarm_mode, want.last,
							" got act %0d cont %0d move %0d", action, contact, movement,
							" ang %0d mode %0d last %0d", angle_report, alarm_mode, last);
				end
			end
		end
	end

	// watchdog: nothing moving on any channel for too long
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
				$display("watchdog: no request moved for %0d cycles, %0d results still owed",
					WATCHDOG_LIMIT, expected_actions.size());
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		reset_tracker();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random_traffic();
		test_backpressure();
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		faults += expected_actions.size();
		$display("ran %0d events and %0d register writes, checked %0d results",
			events_sent, reg_writes, actions_checked);
		$display("covered idle and stall mixes, extreme settings and a %0d cycle hold-off",
			HOLD_CYCLES);
		if (faults == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("%0d faults", faults);
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
